FILE: design/lcns_pkg.sv
package lcns_pkg;

  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CODE_W      = 8;
  localparam int MIN_GRID    = 3;
  localparam int FOREST_LIMIT = 5;
  localparam int AGRI_LIMIT  = 2;
  localparam int WIN_SIZE    = 9;
  localparam int WIN_CENTRE  = 4;
  localparam int FIFO_DEPTH  = 4;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_CLASS_BITS  = 8;

  localparam logic [CFG_W-1:0]  RST_COLUMNS     = 11'd1024;
  localparam logic [CFG_W-1:0]  RST_ROWS        = 11'd1024;
  localparam logic [CODE_W-1:0] RST_FOREST      = 8'd1;
  localparam logic [CODE_W-1:0] RST_AGRICULTURE = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLUMNS     = 2'd0,
    REG_GRID_ROWS        = 2'd1,
    REG_FOREST_CODE      = 2'd2,
    REG_AGRICULTURE_CODE = 2'd3
  } cfg_reg_t;

endpackage

FILE: design/lcns_if.sv
interface lcns_cell_if #(
  parameter int CLASS_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [CLASS_BITS-1:0] cell_class;

  modport source (output valid, output cell_class, input ready);
  modport sink (input valid, input cell_class, output ready);
endinterface

interface lcns_result_if #(
  parameter int ROW_W      = 10,
  parameter int COL_W      = 10,
  parameter int CLASS_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_column;
  logic [CLASS_BITS-1:0] new_class;
  logic                  last_of_run;
  logic                  grid_done;

  modport source (output valid, output out_row, output out_column, output new_class,
                  output last_of_run, output grid_done, input ready);
  modport sink (input valid, input out_row, input out_column, input new_class,
                input last_of_run, input grid_done, output ready);
endinterface

FILE: design/land_class_neighbourhood_smoother.sv
// land-class neighbourhood smoother
// in_cell carries one land-class code per beat, in raster order over a grid of
// grid_rows x grid_columns cells. out_result carries smoothed cells with their row
// and column. border cells leave unchanged; an interior cell leaves when its
// lower-right neighbour arrives, changed by the forest / agriculture count rule
// on its 8 neighbours. one input beat gives zero, one or two result beats; the
// interior cell comes before the border cell, and last_of_run marks the last one.
// grid_done marks the bottom-right cell of the grid.
// an accepted cell sits in the line-store read stage, then moves into the output
// queue. throughput: one input beat per cycle while out_result does not stall and
// each cell gives at most one result; the single output beat per cycle sets the
// rate when a cell gives two.
// reset clears the counters, the 3x3 window and the output queue and loads the
// register defaults (1024 x 1024 grid, forest 1, agriculture 2); the line stores
// are not cleared. when out_result stalls, the four-entry output queue fills and
// in_cell.ready drops until there is room for two results again.
// cfg registers: 0 grid_columns, 1 grid_rows, 2 forest_code, 3 agriculture_code;
// write them only while the block is idle
module land_class_neighbourhood_smoother
  import lcns_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int CLASS_BITS  = DEF_CLASS_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lcns_cell_if.sink            in_cell,
  lcns_result_if.source        out_result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CNW   = $clog2(MAX_COLUMNS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int RES_W = RW + CW + CLASS_BITS + 2;

  logic [CFG_W-1:0]  cols_cfg_r;
  logic [CFG_W-1:0]  rows_cfg_r;
  logic [CODE_W-1:0] forest_r;
  logic [CODE_W-1:0] agri_r;

  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;

  logic [CNW-1:0] cols;
  logic [RNW-1:0] rows;
  logic [CW-1:0]  c_eff;
  logic [RW-1:0]  r_eff;
  logic [CNW-1:0] c_p1;
  logic [RNW-1:0] r_p1;
  logic           col_edge;
  logic           row_edge;

  logic                  s1_valid_r;
  logic [CLASS_BITS-1:0] s1_class_r;
  logic [RW-1:0]         s1_row_r;
  logic [CW-1:0]         s1_col_r;
  logic                  s1_interior_r;
  logic                  s1_border_r;
  logic                  s1_last_r;

  logic                  in_acc;
  logic                  fire;
  logic                  room_for_two;
  logic [CLASS_BITS-1:0] top_cell;
  logic [CLASS_BITS-1:0] mid_cell;
  logic [CLASS_BITS-1:0] smoothed;
  logic [CLASS_BITS-1:0] forest;
  logic [CLASS_BITS-1:0] agri;
  logic [RES_W-1:0]      res_inner;
  logic [RES_W-1:0]      res_border;
  logic [RES_W-1:0]      res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= RST_COLUMNS;
      rows_cfg_r <= RST_ROWS;
      forest_r   <= RST_FOREST;
      agri_r     <= RST_AGRICULTURE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_COLUMNS:     cols_cfg_r <= cfg_data;
        REG_GRID_ROWS:        rows_cfg_r <= cfg_data;
        REG_FOREST_CODE:      forest_r   <= cfg_data[CODE_W-1:0];
        REG_AGRICULTURE_CODE: agri_r     <= cfg_data[CODE_W-1:0];
      endcase
    end
  end

  assign forest = CLASS_BITS'(forest_r);
  assign agri   = CLASS_BITS'(agri_r);

  // grid size held within 3 .. max
  always_comb begin
    priority if (cols_cfg_r < CFG_W'(MIN_GRID)) begin
      cols = CNW'(MIN_GRID);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLUMNS)) begin
      cols = CNW'(MAX_COLUMNS);
    end else begin
      cols = CNW'(cols_cfg_r);
    end
    priority if (rows_cfg_r < CFG_W'(MIN_GRID)) begin
      rows = RNW'(MIN_GRID);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows = RNW'(MAX_ROWS);
    end else begin
      rows = RNW'(rows_cfg_r);
    end
  end

  always_comb begin
    c_eff    = (CNW'(col_cnt_r) >= cols) ? '0 : col_cnt_r;
    r_eff    = (RNW'(row_cnt_r) >= rows) ? '0 : row_cnt_r;
    c_p1     = CNW'(c_eff) + CNW'(1);
    r_p1     = RNW'(r_eff) + RNW'(1);
    col_edge = (c_eff == '0) || (c_p1 == cols);
    row_edge = (r_eff == '0) || (r_p1 == rows);
  end

  assign fire          = s1_valid_r && room_for_two;
  assign in_cell.ready = !s1_valid_r || fire;
  assign in_acc        = in_cell.valid && in_cell.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        if (c_p1 >= cols) begin
          col_cnt_r <= '0;
          row_cnt_r <= (r_p1 >= rows) ? '0 : RW'(r_p1);
        end else begin
          col_cnt_r <= CW'(c_p1);
          row_cnt_r <= r_eff;
        end
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_class_r    <= in_cell.cell_class;
      s1_row_r      <= r_eff;
      s1_col_r      <= c_eff;
      s1_interior_r <= (r_eff >= RW'(2)) && (c_eff >= CW'(2));
      s1_border_r   <= col_edge || row_edge;
      s1_last_r     <= (c_p1 == cols) && (r_p1 == rows);
    end
  end

  lcns_line_store #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (CLASS_BITS)
  ) u_upper (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (c_eff),
    .rd_data (top_cell),
    .wr_en   (fire),
    .wr_addr (s1_col_r),
    .wr_data (mid_cell)
  );

  lcns_line_store #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (CLASS_BITS)
  ) u_middle (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (c_eff),
    .rd_data (mid_cell),
    .wr_en   (fire),
    .wr_addr (s1_col_r),
    .wr_data (s1_class_r)
  );

  lcns_window #(
    .CLASS_BITS (CLASS_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (fire),
    .top_cell (top_cell),
    .mid_cell (mid_cell),
    .new_cell (s1_class_r),
    .forest   (forest),
    .agri     (agri),
    .smoothed (smoothed)
  );

  // result beat: row, column, class, last_of_run, grid_done
  assign res_inner  = {s1_row_r - RW'(1), s1_col_r - CW'(1), smoothed,
                       !s1_border_r, 1'b0};
  assign res_border = {s1_row_r, s1_col_r, s1_class_r, 1'b1, s1_last_r};
  assign res_head   = s1_interior_r ? res_inner : res_border;

  lcns_out_fifo #(
    .WIDTH (RES_W)
  ) u_out_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push0        (fire && (s1_interior_r || s1_border_r)),
    .push1        (fire && s1_interior_r && s1_border_r),
    .data0        (res_head),
    .data1        (res_border),
    .room_for_two (room_for_two),
    .out_valid    (out_result.valid),
    .out_ready    (out_result.ready),
    .out_data     ({out_result.out_row, out_result.out_column, out_result.new_class,
                    out_result.last_of_run, out_result.grid_done})
  );

endmodule

FILE: design/lcns_line_store.sv
module lcns_line_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/lcns_window.sv
module lcns_window
  import lcns_pkg::*;
#(
  parameter int CLASS_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic [CLASS_BITS-1:0] top_cell,
  input  logic [CLASS_BITS-1:0] mid_cell,
  input  logic [CLASS_BITS-1:0] new_cell,
  input  logic [CLASS_BITS-1:0] forest,
  input  logic [CLASS_BITS-1:0] agri,
  output logic [CLASS_BITS-1:0] smoothed
);

  logic [CLASS_BITS-1:0] win_r   [WIN_SIZE];
  logic [CLASS_BITS-1:0] win_nxt [WIN_SIZE];
  logic [3:0]            n_forest;
  logic [3:0]            n_agri;
  logic [CLASS_BITS-1:0] centre;

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top_cell;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_cell;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = new_cell;
  end

  // neighbour counts on the window as it stands after this shift
  always_comb begin
    n_forest = 4'd0;
    n_agri   = 4'd0;
    for (int k = 0; k < WIN_SIZE; k++) begin
      if (k != WIN_CENTRE) begin
        n_forest = n_forest + 4'(win_nxt[k] == forest);
        n_agri   = n_agri + 4'(win_nxt[k] == agri);
      end
    end
    centre = win_nxt[WIN_CENTRE];
    priority if (n_forest > 4'(FOREST_LIMIT)) begin
      smoothed = (centre == agri) ? forest : centre;
    end else if (n_agri > 4'(AGRI_LIMIT) && centre == forest) begin
      smoothed = agri;
    end else begin
      smoothed = centre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_SIZE; k++) begin
        win_r[k] <= '0;
      end
    end else if (shift_en) begin
      for (int k = 0; k < WIN_SIZE; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

endmodule

FILE: design/lcns_out_fifo.sv
module lcns_out_fifo
  import lcns_pkg::*;
#(
  parameter int WIDTH = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push0,
  input  logic             push1,
  input  logic [WIDTH-1:0] data0,
  input  logic [WIDTH-1:0] data1,
  output logic             room_for_two,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             pop;
  logic [CNT_W-1:0] n_push;

  assign pop          = out_valid && out_ready;
  assign out_valid    = (count_r != '0);
  assign out_data     = slot_r[rd_ptr_r];
  assign room_for_two = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_p1    = wr_ptr_r + PTR_W'(1);
  assign n_push       = CNT_W'(push0) + CNT_W'(push1);
  assign count_nxt    = count_r + n_push - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push0) begin
      slot_r[wr_ptr_r] <= data0;
    end
    if (push1) begin
      slot_r[wr_ptr_p1] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule
